@@ hdl/lcp_pkg.sv @@
// Package for the line command parser: reply codes, character codes,
// and the reply word type shared by the parse stage and the top level.
// No dependencies.
package lcp_pkg;

  localparam int unsigned VALUE_W = 20;

  localparam logic [1:0] KIND_FREQ = 2'd0;
  localparam logic [1:0] KIND_AMP  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [VALUE_W-1:0] MAG_MAX  = 20'd999999;
  localparam logic [VALUE_W-1:0] AMP_MAX  = 20'd100;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;
  } reply_t;

endpackage

@@ hdl/lcp_line_fsm.sv @@
// Per-byte line parse stage: tracks line length, command letter, sign and
// the running decimal magnitude, and forms the reply when a line ends or overflows.
// Depends on lcp_pkg.
module lcp_line_fsm #(
  parameter int unsigned LINE_BUFFER_BYTES = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  output lcp_pkg::reply_t rsp
);
  import lcp_pkg::*;

  localparam int unsigned CNT_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [CNT_W-1:0] LINE_CAP = CNT_W'(LINE_BUFFER_BYTES - 1);

  localparam logic [1:0] PH_BLANK = 2'd0;
  localparam logic [1:0] PH_DIGIT = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  localparam logic [1:0] LN_FREQ  = 2'd0;
  localparam logic [1:0] LN_AMP   = 2'd1;
  localparam logic [1:0] LN_OTHER = 2'd2;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [1:0]         line_r, line_nxt;
  logic               neg_r, neg_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;

  logic               is_term, is_blank, is_sign, is_digit;
  logic [23:0]        acc_sum;
  logic [VALUE_W-1:0] acc_sat;

  assign is_term  = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                    (rx_byte == CH_VT) || (rx_byte == CH_FF);
  assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

  assign acc_sum = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0}
                 + {20'd0, 4'(rx_byte - CH_ZERO)};
  assign acc_sat = (acc_sum > 24'(MAG_MAX)) ? MAG_MAX : acc_sum[VALUE_W-1:0];

  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    line_nxt  = line_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    rsp       = '{valid: 1'b0, kind: KIND_ERR, value: '0};
    if (step) begin
      if (is_term) begin
        count_nxt = '0;
        rsp.valid = 1'b1;
        if (count_r != '0) begin
          unique case (line_r)
            LN_FREQ: begin
              if (!neg_r && (mag_r != '0)) begin
                rsp.kind  = KIND_FREQ;
                rsp.value = mag_r;
              end
            end
            LN_AMP: begin
              if (mag_r == '0) begin
                rsp.kind = KIND_AMP;
              end else if (!neg_r && (mag_r <= AMP_MAX)) begin
                rsp.kind  = KIND_AMP;
                rsp.value = mag_r;
              end
            end
            default: begin
              rsp.kind = KIND_ERR;
            end
          endcase
        end
      end else if (count_r == LINE_CAP) begin
        count_nxt = '0;
        rsp.valid = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
        if (count_r == '0) begin
          phase_nxt = PH_BLANK;
          neg_nxt   = 1'b0;
          mag_nxt   = '0;
          if (rx_byte == CH_F) begin
            line_nxt = LN_FREQ;
          end else if (rx_byte == CH_A) begin
            line_nxt = LN_AMP;
          end else begin
            line_nxt = LN_OTHER;
          end
        end else begin
          unique case (phase_r)
            PH_BLANK: begin
              if (is_digit) begin
                mag_nxt   = acc_sat;
                phase_nxt = PH_DIGIT;
              end else if (is_sign) begin
                neg_nxt   = (rx_byte == CH_MINUS);
                phase_nxt = PH_DIGIT;
              end else if (!is_blank) begin
                phase_nxt = PH_DONE;
              end
            end
            PH_DIGIT: begin
              if (is_digit) begin
                mag_nxt = acc_sat;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            default: begin
              phase_nxt = PH_DONE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    line_r  <= line_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
  end

endmodule

@@ hdl/line_command_parser_core.sv @@
// Line command parser top level: input byte register, parse stage, reply
// register. A terminating or overflowing byte is accepted into the byte
// register, and its reply is loaded into the reply register when the output
// advances. Throughput: one byte per cycle; the input stalls only while a
// byte is held and the held reply is stalled at the output.
// Reset (rst_n low, synchronous) empties the line and drops held words.
// Depends on lcp_pkg and lcp_line_fsm.
module line_command_parser_core #(
  parameter int unsigned LINE_BUFFER_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_reply_kind,
  output logic [lcp_pkg::VALUE_W-1:0] out_reply_value
);
  import lcp_pkg::*;

  logic               byte_valid_r, byte_valid_nxt;
  logic [7:0]         byte_r;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         kind_r;
  logic [VALUE_W-1:0] value_r;
  logic               advance;
  reply_t             rsp;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = byte_valid_r && !advance;

  lcp_line_fsm #(
    .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
  ) u_line_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (byte_valid_r && advance),
    .rx_byte(byte_r),
    .rsp    (rsp)
  );

  always_comb begin
    byte_valid_nxt = byte_valid_r;
    out_valid_nxt  = out_valid_r;
    if (!in_stall) begin
      byte_valid_nxt = in_valid;
    end
    if (advance) begin
      out_valid_nxt  = rsp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_valid_r <= byte_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r <= in_rx_byte;
    end
    if (advance && rsp.valid) begin
      kind_r  <= rsp.kind;
      value_r <= rsp.value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reply_kind  = kind_r;
  assign out_reply_value = value_r;

endmodule
